@@ hw/rtl/mbu_pkg.sv @@
// mbu_pkg: shared types and constants of the measurement batch unpacker.
// Holds the request and result payload structs and the field size constants.
// No dependencies.
package mbu_pkg;

	// Number of little-endian id bytes that open each group.
	localparam int ID_BYTES = 4;
	// Flag varint bits kept before the cut to 32 bits.
	localparam int FLAG_BITS = 32;

	// Mask applied to the decoded flag varint.
	localparam logic [63:0] FLAG_MASK = (FLAG_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << FLAG_BITS) - 64'd1);

	// Widths of the internal counters and the accumulator.
	localparam int IDX_W = 4;
	localparam int ACC_W = 64;
	// Last varint byte index whose payload still lands inside the accumulator.
	localparam logic [IDX_W-1:0] VARINT_LAST_IDX = 4'd9;
	// Saturation value of the byte counter.
	localparam logic [IDX_W-1:0] IDX_MAX = 4'd15;

	// One payload byte of a message.
	typedef struct packed {
		logic [7:0]  byte_value;
		logic        message_start;
		logic [15:0] record_total;
	} mbu_req_t;

	// One decoded record.
	typedef struct packed {
		logic [31:0] meas_id;
		logic [31:0] meas_flag;
		logic [63:0] meas_time;
		logic [63:0] value_bits;
		logic        last_record;
	} mbu_res_t;

endpackage

@@ hw/rtl/mbu_in_stage.sv @@
// mbu_in_stage: input register of the unpacker.
// Captures one request per cycle and holds it while the parser is stalled.
// Depends on mbu_pkg.
module mbu_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mbu_pkg::mbu_req_t req_data,
	input  logic              advance,
	output logic              valid_s1,
	output mbu_pkg::mbu_req_t data_s1
);

	// Room for a new request whenever the held one moves on this cycle
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Payload register, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			data_s1 <= req_data;
		end
	end

endmodule

@@ hw/rtl/mbu_parser.sv @@
// mbu_parser: message parse state and the per-byte decode step.
// Updates the group and varint state for each byte and forms the result.
// Depends on mbu_pkg.
module mbu_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  mbu_pkg::mbu_req_t data_s1,
	output logic              hit,
	output mbu_pkg::mbu_res_t res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ID,
		PH_GCOUNT,
		PH_FLAG,
		PH_TIME,
		PH_VALUE
	} phase_t;

	phase_t                        phase_q, ph_c, ph_d;
	logic [mbu_pkg::IDX_W-1:0]     idx_q, idx_c, idx_d;
	logic [mbu_pkg::ACC_W-1:0]     acc_q, acc_c, acc_d;
	logic [31:0]                   gid_q, gid_d;
	logic [15:0]                   grem_q, grem_c, grem_d;
	logic [15:0]                   tot_q, tot_c, tot_d;
	logic [31:0]                   hflag_q, hflag_d;
	logic [63:0]                   htime_q, htime_d;

	logic [7:0]                    b;
	logic [6:0]                    vshift;
	logic [mbu_pkg::ACC_W-1:0]     vacc;
	logic [mbu_pkg::IDX_W-1:0]     vidx;
	logic                          vend;
	logic [mbu_pkg::ACC_W-1:0]     bacc;
	logic [mbu_pkg::IDX_W-1:0]     bidx;
	logic [15:0]                   tot_dec;
	logic [15:0]                   grem_dec;

	assign b = data_s1.byte_value;

	// Start mark restarts the message before the byte is parsed
	always_comb begin
		ph_c   = phase_q;
		idx_c  = idx_q;
		acc_c  = acc_q;
		tot_c  = tot_q;
		grem_c = grem_q;
		if (data_s1.message_start) begin
			tot_c  = data_s1.record_total;
			grem_c = 16'd0;
			idx_c  = '0;
			acc_c  = '0;
			ph_c   = (data_s1.record_total == 16'd0) ? PH_IDLE : PH_ID;
		end
	end

	// LEB128 step: 7 payload bits at 7*index, counter saturates
	always_comb begin
		vshift = 7'(idx_c) * 7'd7;
		vacc   = acc_c;
		if (idx_c <= mbu_pkg::VARINT_LAST_IDX) begin
			vacc = acc_c | (mbu_pkg::ACC_W'(b[6:0]) << vshift[5:0]);
		end
		vidx = (idx_c == mbu_pkg::IDX_MAX) ? idx_c : idx_c + 4'd1;
		vend = !b[7];
	end

	// Little-endian byte step for the id and group count
	always_comb begin
		bacc = acc_c;
		if (ph_c == PH_ID) begin
			if (idx_c < 4'd8) begin
				bacc = acc_c | (mbu_pkg::ACC_W'(b) << {idx_c[2:0], 3'b000});
			end
		end else begin
			bacc = acc_c | (mbu_pkg::ACC_W'(b) << {idx_c[0], 3'b000});
		end
		bidx = idx_c + 4'd1;
	end

	assign tot_dec  = tot_c - 16'd1;
	assign grem_dec = grem_c - 16'd1;

	// Phase transitions and held fields
	always_comb begin
		ph_d    = ph_c;
		idx_d   = idx_c;
		acc_d   = acc_c;
		tot_d   = tot_c;
		grem_d  = grem_c;
		gid_d   = gid_q;
		hflag_d = hflag_q;
		htime_d = htime_q;
		hit     = 1'b0;
		case (ph_c)
			PH_IDLE: begin
				ph_d = PH_IDLE;
			end
			PH_ID: begin
				acc_d = bacc;
				idx_d = bidx;
				if (bidx >= mbu_pkg::IDX_W'(mbu_pkg::ID_BYTES)) begin
					gid_d = bacc[31:0];
					ph_d  = PH_GCOUNT;
					idx_d = '0;
					acc_d = '0;
				end
			end
			PH_GCOUNT: begin
				acc_d = bacc;
				idx_d = bidx;
				if (bidx >= 4'd2) begin
					grem_d = bacc[15:0];
					ph_d   = (bacc[15:0] == 16'd0) ? PH_ID : PH_FLAG;
					idx_d  = '0;
					acc_d  = '0;
				end
			end
			PH_FLAG: begin
				acc_d = vacc;
				idx_d = vidx;
				if (vend) begin
					hflag_d = 32'(vacc & mbu_pkg::FLAG_MASK);
					ph_d    = PH_TIME;
					idx_d   = '0;
					acc_d   = '0;
				end
			end
			PH_TIME: begin
				acc_d = vacc;
				idx_d = vidx;
				if (vend) begin
					htime_d = vacc;
					ph_d    = PH_VALUE;
					idx_d   = '0;
					acc_d   = '0;
				end
			end
			PH_VALUE: begin
				acc_d = vacc;
				idx_d = vidx;
				if (vend) begin
					hit    = 1'b1;
					tot_d  = tot_dec;
					grem_d = grem_dec;
					idx_d  = '0;
					acc_d  = '0;
					if (tot_dec == 16'd0) begin
						ph_d = PH_IDLE;
					end else if (grem_dec == 16'd0) begin
						ph_d = PH_ID;
					end else begin
						ph_d = PH_FLAG;
					end
				end
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase
	end

	// Result fields of a completed record
	always_comb begin
		res.meas_id     = gid_q;
		res.meas_flag   = hflag_q;
		res.meas_time   = htime_q;
		res.value_bits  = vacc;
		res.last_record = (tot_dec == 16'd0);
	end

	// Parse state, updated once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			acc_q   <= '0;
			gid_q   <= '0;
			grem_q  <= '0;
			tot_q   <= '0;
			hflag_q <= '0;
			htime_q <= '0;
		end else if (fire) begin
			phase_q <= ph_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
			gid_q   <= gid_d;
			grem_q  <= grem_d;
			tot_q   <= tot_d;
			hflag_q <= hflag_d;
			htime_q <= htime_d;
		end
	end

endmodule

@@ hw/rtl/mbu_out_stage.sv @@
// mbu_out_stage: result register of the unpacker.
// Holds one decoded record until the receiver takes it; drives the stall.
// Depends on mbu_pkg.
module mbu_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic              hit,
	input  mbu_pkg::mbu_res_t res,
	output logic              advance,
	output logic              res_valid,
	input  logic              res_ready,
	output mbu_pkg::mbu_res_t res_data
);

	logic res_valid_q;
	mbu_pkg::mbu_res_t res_q;

	// Pipeline moves when the result slot is empty or being drained
	assign advance = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && hit) begin
			res_q <= res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

@@ hw/rtl/measurement_batch_unpacker.sv @@
// measurement_batch_unpacker: top level of the measurement record decoder.
// Instantiates mbu_in_stage, mbu_parser and mbu_out_stage; uses mbu_pkg.
//
// Usage:
//   The request channel (req_valid/req_ready/req_data) carries one message
//   byte per request. The first byte of a message carries message_start and
//   the total record count. The result channel (res_valid/res_ready/res_data)
//   delivers one decoded record per request that ends a value varint, with
//   last_record set on the record that completes the total.
//   Throughput: one request per cycle while no result waits on res_ready; the
//   per-byte decode step between the input register and the result register sets that figure.
//   Path: a request that ends a record is held in the input register, then
//   its decoded record is registered in the result register.
//   Stall: while a result waits, the input register still takes one request;
//   after that req_ready drops until res_ready is seen.
//   Reset: arst_n clears both registers' valid bits and the parse state to
//   idle, so bytes are ignored until a message start arrives.
module measurement_batch_unpacker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mbu_pkg::mbu_req_t req_data,
	output logic              res_valid,
	input  logic              res_ready,
	output mbu_pkg::mbu_res_t res_data
);

	logic              advance;
	logic              valid_s1;
	mbu_pkg::mbu_req_t data_s1;
	logic              hit;
	mbu_pkg::mbu_res_t res;

	mbu_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1)
	);

	mbu_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s1 && advance),
		.data_s1 (data_s1),
		.hit     (hit),
		.res     (res)
	);

	mbu_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.hit       (hit),
		.res       (res),
		.advance   (advance),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

@@ hw/rtl/mbu_checker.sv @@
// mbu_checker: port-level assertions for measurement_batch_unpacker.
// Bound to the top level below; uses mbu_pkg for the payload types.
module mbu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              res_valid,
	input logic              res_ready,
	input mbu_pkg::mbu_res_t res_data
);

	// A stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// No result is shown while in reset
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A draining receiver never stalls the request side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> req_ready)
		else $error("request stalled while result side drains");

	// An empty pipeline always takes a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && $past(!req_valid) && $past(arst_n) |-> req_ready)
		else $error("request refused with empty pipeline");

endmodule

bind measurement_batch_unpacker mbu_checker u_mbu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
